// ===== hdl/gaussian_polar_generator_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef GAUSSIAN_POLAR_GENERATOR_UNIT_ASSERT_SVH
`define GAUSSIAN_POLAR_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GPG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GPG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/gpg_pkg.sv =====
package gpg_pkg;

	localparam int UNIFORM_BITS = 16;
	localparam int FRAC_U = UNIFORM_BITS - 1;
	localparam int R_W = 2 * UNIFORM_BITS;
	localparam int NRM_W = 2 * FRAC_U + 1;
	localparam int LOG_FRAC = 24;
	localparam int LCNT_W = $clog2(LOG_FRAC + 1);
	localparam int ZW = $clog2(2 * FRAC_U + 1);
	localparam int LW = ZW + LOG_FRAC;
	localparam int LN_W = 25;
	localparam logic [LN_W-1:0] LN2X2_Q24 = LN_W'(23258160);
	localparam int RAD_W = 2 * FRAC_U + 18;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W = ROOT_W + 3;
	localparam int CNT_W = $clog2(RAD_W + 1);
	localparam int NORM_W = 24;
	localparam int MEAN_W = 32;
	localparam int SPREAD_W = 31;
	localparam int SCL_W = NORM_W + SPREAD_W - 19;

	typedef enum logic {
		ISU_SQRT,
		ISU_DIV
	} isu_op_t;

	typedef struct packed {
		logic    start;
		isu_op_t op;
	} isu_req_t;

	// Clamp a quotient magnitude to the signed normal range and apply the sign.
	function automatic logic [NORM_W-1:0] sat_norm(logic [RAD_W-1:0] n, logic neg);
		logic [RAD_W-1:0] lim;
		lim = RAD_W'(1) << (NORM_W - 1);
		if (neg) begin
			sat_norm = (n >= lim) ? {1'b1, {(NORM_W-1){1'b0}}} : NORM_W'(~n + 1'b1);
		end else begin
			sat_norm = (n >= lim) ? {1'b0, {(NORM_W-1){1'b1}}} : n[NORM_W-1:0];
		end
	endfunction

endpackage

// ===== hdl/gpg_item_if.sv =====
interface gpg_item_if;
	import gpg_pkg::*;
	logic valid;
	logic ready;
	logic signed [UNIFORM_BITS-1:0] x_uniform;
	logic signed [UNIFORM_BITS-1:0] y_uniform;
	logic signed [MEAN_W-1:0] mean;
	logic [SPREAD_W-1:0] spread;
	modport source (output valid, x_uniform, y_uniform, mean, spread, input ready);
	modport sink (input valid, x_uniform, y_uniform, mean, spread, output ready);
endinterface

// ===== hdl/gpg_result_if.sv =====
interface gpg_result_if;
	logic valid;
	logic ready;
	logic signed [31:0] normal_value;
	logic from_cache;
	modport source (output valid, normal_value, from_cache, input ready);
	modport sink (input valid, normal_value, from_cache, output ready);
endinterface

// ===== hdl/gpg_root_div_unit.sv =====
module gpg_root_div_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gpg_pkg::isu_req_t           req,
	input  logic [gpg_pkg::RAD_W-1:0]   operand,
	input  logic [gpg_pkg::ROOT_W-1:0]  divisor,
	output logic                        done,
	output logic [gpg_pkg::RAD_W-1:0]   result
);
	import gpg_pkg::*;

	logic              busy_q;
	logic              done_q;
	isu_op_t           op_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RAD_W-1:0]  src_q;
	logic [REM_W-1:0]  rem_q;
	logic [RAD_W-1:0]  res_q;
	logic [ROOT_W-1:0] div_q;
	logic [REM_W-1:0]  rem_n;
	logic [REM_W-1:0]  trial;
	logic              take;

	// one result bit per cycle: restoring square root or restoring divide
	always_comb begin
		if (op_q == ISU_SQRT) begin
			rem_n = {rem_q[REM_W-3:0], src_q[RAD_W-1 -: 2]};
			trial = {{(REM_W-ROOT_W-2){1'b0}}, res_q[ROOT_W-1:0], 2'b01};
		end else begin
			rem_n = {rem_q[REM_W-2:0], src_q[RAD_W-1]};
			trial = {{(REM_W-ROOT_W){1'b0}}, div_q};
		end
		take = (rem_n >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= ISU_SQRT;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == ISU_SQRT) ? CNT_W'(ROOT_W) : CNT_W'(RAD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			src_q <= operand;
			rem_q <= '0;
			res_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? (rem_n - trial) : rem_n;
			res_q <= {res_q[RAD_W-2:0], take};
			src_q <= (op_q == ISU_SQRT) ? (src_q << 2) : (src_q << 1);
		end
	end

	assign done   = done_q;
	assign result = res_q;
endmodule

// ===== hdl/gaussian_polar_generator_unit.sv =====
// Channel  | Dir | Payload                                      | Transfer
// item     | in  | x_uniform, y_uniform, mean, spread           | valid && ready
// result   | out | normal_value, from_cache                     | valid && ready
//
// A cached item goes straight to the scale and output steps. A fresh pair runs the
// normalisation, the 24-step log loop and a multiply, then two roots and two
// divides on the bit-serial root/divide unit, then scale and output. A rejected
// pair returns to idle from the check step.
// Reset clears the sequencer, cache flag and result valid; no clearing pass.
// item.ready is high only while the sequencer idles; a stalled result holds
// the sequencer in its last step until the result transfer.
module gaussian_polar_generator_unit (
	input logic         clk,
	input logic         arst_n,
	gpg_item_if.sink    item,
	gpg_result_if.source result
);
	import gpg_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_NORM, S_LOG, S_WMUL, S_ROOT_W, S_ROOT_R,
		S_DIV_X, S_DIV_Y, S_SCALE, S_OUT
	} state_t;

	state_t                     state_q;
	logic                       cache_full_q;
	logic signed [NORM_W-1:0]   cache_q;
	logic                       o_valid_q;
	logic signed [31:0]         o_value_q;
	logic                       o_cache_q;
	isu_req_t                   req_q;

	// item payload, held for the whole item
	logic signed [UNIFORM_BITS-1:0] x_q, y_q;
	logic signed [MEAN_W-1:0]   mean_q;
	logic [SPREAD_W-1:0]        spread_q;

	logic [R_W-1:0]             r_q;
	logic [NRM_W-1:0]           m_q;
	logic [ZW-1:0]              z_q;
	logic [LCNT_W-1:0]          lcnt_q;
	logic [LOG_FRAC-1:0]        frac_q;
	logic [ROOT_W-1:0]          s_q;
	logic [ROOT_W-1:0]          q_q;
	logic signed [NORM_W-1:0]   n1_q;
	logic signed [NORM_W-1:0]   nsel_q;
	logic [SCL_W-1:0]           prod_q;
	logic [RAD_W-1:0]           operand_q;
	logic                       from_cache_q;

	logic                       done;
	logic [RAD_W-1:0]           unit_res;

	logic                       accept;
	logic [R_W-1:0]             r_in;
	logic [2*NRM_W-1:0]         sq;
	logic [NRM_W:0]             sq_sh;
	logic [LW-1:0]              lval;
	logic [LW+LN_W-1:0]         wprod;
	logic [UNIFORM_BITS-1:0]    mag_x, mag_y;
	logic [NORM_W-1:0]          mag_n;
	logic signed [SCL_W+1:0]    sum;
	logic signed [31:0]         sat_sum;
	logic                       out_free;
	logic                       unit_go;
	isu_op_t                    unit_op;

	gpg_root_div_unit u_unit (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_q),
		.operand (operand_q),
		.divisor (q_q),
		.done    (done),
		.result  (unit_res)
	);

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;
	assign out_free   = !o_valid_q || result.ready;

	always_comb begin
		r_in  = R_W'(item.x_uniform * item.x_uniform) + R_W'(item.y_uniform * item.y_uniform);
		// one squaring step of the log loop, truncated back to Q1.30
		sq    = m_q * m_q;
		sq_sh = sq[2*NRM_W-1 -: NRM_W+1];
		lval  = {z_q, {LOG_FRAC{1'b0}}} - LW'(frac_q);
		wprod = lval * LN2X2_Q24;
		mag_x = x_q[UNIFORM_BITS-1] ? UNIFORM_BITS'(~x_q + 1'b1) : UNIFORM_BITS'(x_q);
		mag_y = y_q[UNIFORM_BITS-1] ? UNIFORM_BITS'(~y_q + 1'b1) : UNIFORM_BITS'(y_q);
		mag_n = nsel_q[NORM_W-1] ? NORM_W'(~nsel_q + 1'b1) : NORM_W'(nsel_q);
		sum   = (nsel_q[NORM_W-1] ? -$signed({2'b00, prod_q}) : $signed({2'b00, prod_q}))
		        + (SCL_W+2)'(mean_q);
		if (sum > (SCL_W+2)'(32'sh7FFFFFFF)) begin
			sat_sum = 32'sh7FFFFFFF;
		end else if (sum < -(SCL_W+2)'(33'sh080000000)) begin
			sat_sum = 32'sh80000000;
		end else begin
			sat_sum = sum[31:0];
		end
		// start the shared unit on entry to each root and divide step
		unit_go = (state_q == S_WMUL) || (done && (state_q == S_ROOT_W ||
			state_q == S_ROOT_R || state_q == S_DIV_X));
		unit_op = (state_q == S_ROOT_R || state_q == S_DIV_X) ? ISU_DIV : ISU_SQRT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cache_full_q <= 1'b0;
			cache_q      <= '0;
			o_valid_q    <= 1'b0;
			req_q        <= '{start: 1'b0, op: ISU_SQRT};
		end else begin
			req_q <= '{start: unit_go, op: unit_op};
			if (state_q == S_OUT && out_free) begin
				o_valid_q <= 1'b1;
			end else if (result.ready) begin
				o_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cache_full_q) begin
							// serve the cached second normal, ignore the pair
							nsel_q       <= cache_q;
							from_cache_q <= 1'b1;
							cache_full_q <= 1'b0;
							state_q      <= S_SCALE;
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					// drop a pair outside the unit disc or at the origin
					if (r_q == '0 || r_q > (R_W'(1) << (2 * FRAC_U))) begin
						state_q <= S_IDLE;
					end else begin
						m_q     <= r_q[NRM_W-1:0];
						z_q     <= '0;
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (m_q[NRM_W-1]) begin
						lcnt_q  <= '0;
						frac_q  <= '0;
						state_q <= S_LOG;
					end else begin
						m_q <= m_q << 1;
						z_q <= z_q + 1'b1;
					end
				end
				S_LOG: begin
					m_q    <= sq_sh[NRM_W] ? sq_sh[NRM_W:1] : sq_sh[NRM_W-1:0];
					frac_q <= {frac_q[LOG_FRAC-2:0], sq_sh[NRM_W]};
					lcnt_q <= lcnt_q + 1'b1;
					if (lcnt_q == LCNT_W'(LOG_FRAC - 1)) begin
						state_q <= S_WMUL;
					end
				end
				S_WMUL: begin
					operand_q <= RAD_W'(wprod >> 8);
					state_q   <= S_ROOT_W;
				end
				S_ROOT_W: begin
					if (done) begin
						s_q       <= unit_res[ROOT_W-1:0];
						operand_q <= RAD_W'({r_q, 16'b0});
						state_q   <= S_ROOT_R;
					end
				end
				S_ROOT_R: begin
					if (done) begin
						q_q       <= unit_res[ROOT_W-1:0];
						operand_q <= RAD_W'({(UNIFORM_BITS+ROOT_W)'(mag_x) * s_q, 7'b0});
						state_q   <= S_DIV_X;
					end
				end
				S_DIV_X: begin
					if (done) begin
						n1_q      <= sat_norm(unit_res, x_q[UNIFORM_BITS-1]);
						operand_q <= RAD_W'({(UNIFORM_BITS+ROOT_W)'(mag_y) * s_q, 7'b0});
						state_q   <= S_DIV_Y;
					end
				end
				S_DIV_Y: begin
					if (done) begin
						cache_q      <= sat_norm(unit_res, y_q[UNIFORM_BITS-1]);
						cache_full_q <= 1'b1;
						nsel_q       <= n1_q;
						from_cache_q <= 1'b0;
						state_q      <= S_SCALE;
					end
				end
				S_SCALE: begin
					prod_q  <= SCL_W'(((NORM_W+SPREAD_W)'(mag_n) * spread_q) >> 19);
					state_q <= S_OUT;
				end
				S_OUT: begin
					// hold until the output register is free
					if (out_free) begin
						o_value_q <= sat_sum;
						o_cache_q <= from_cache_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload capture at the item transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q      <= item.x_uniform;
			y_q      <= item.y_uniform;
			mean_q   <= item.mean;
			spread_q <= item.spread;
			r_q      <= r_in;
		end
	end

	assign result.valid        = o_valid_q;
	assign result.normal_value = o_value_q;
	assign result.from_cache   = o_cache_q;
endmodule

// ===== hdl/gpg_checker.sv =====
`include "gaussian_polar_generator_unit_assert.svh"

module gpg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [31:0] normal_value
);
	`GPG_ASSERT_NEXT(a_busy_after_item, item_valid && item_ready, !item_ready, "ready after transfer")
	`GPG_ASSERT_NOW(a_result_while_busy, $rose(result_valid), $past(!item_ready), "result while idle")
	`GPG_ASSERT_NEXT(a_valid_held, result_valid && !result_ready, result_valid, "valid dropped")
	`GPG_ASSERT_NEXT(a_value_held, result_valid && !result_ready, $stable(normal_value), "value moved")
endmodule

bind gaussian_polar_generator_unit gpg_checker u_gpg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.normal_value (result.normal_value)
);

// ===== bench/gaussian_polar_generator_unit_test.sv =====
module gaussian_polar_generator_unit_test;
	import gpg_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 2000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		logic signed [31:0] normal_value;
		logic               from_cache;
	} normal_result_t;

	logic clk;
	logic arst_n;
	gpg_item_if   item_ch();
	gpg_result_if result_ch();

	// Predictor copy of the block's state.
	logic signed [NORM_W-1:0] held_normal;
	logic                     held_valid;

	normal_result_t pending_normals[$];
	int errors;
	int idle_cycles;
	bit calm;

	gaussian_polar_generator_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// -log2 of r scaled by 2^-2F, Q.24, by repeated squaring of the mantissa.
	function automatic longint unsigned neg_log2_q24(longint unsigned r);
		int p;
		longint unsigned m;
		longint unsigned frac;
		p = 0;
		frac = 0;
		while (p < 63 && (r >> (p + 1)) != 0)
			p++;
		m = (p >= 30) ? (r >> (p - 30)) : (r << (30 - p));
		for (int i = 1; i <= LOG_FRAC; i++) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m >>= 1;
				frac |= 64'd1 << (LOG_FRAC - i);
			end
		end
		return (longint'(2 * FRAC_U - p) << 24) - frac;
	endfunction

	function automatic logic signed [NORM_W-1:0] normal_from(longint u, longint unsigned s,
			longint unsigned q);
		longint unsigned mag;
		longint unsigned n;
		mag = (u < 0) ? longint'(-u) : longint'(u);
		n = (mag * s * 128) / q;
		if (u < 0)
			return (n >= 64'd8388608) ? -24'sd8388608 : NORM_W'(-longint'(n));
		return (n > 64'd8388607) ? 24'sd8388607 : NORM_W'(n);
	endfunction

	function automatic logic signed [31:0] scale_add(logic signed [NORM_W-1:0] n,
			logic [SPREAD_W-1:0] spread, logic signed [31:0] mean);
		longint nl;
		longint unsigned mag;
		longint prod;
		longint sum;
		nl = n;
		mag = (nl < 0) ? -nl : nl;
		prod = longint'((mag * spread) >> 19);
		sum = ((nl < 0) ? -prod : prod) + longint'(mean);
		if (sum > 64'sd2147483647)
			sum = 64'sd2147483647;
		if (sum < -64'sd2147483648)
			sum = -64'sd2147483648;
		return sum[31:0];
	endfunction

	// Advance the predictor by one accepted item and queue its result, if any.
	task automatic predict_normal(logic signed [UNIFORM_BITS-1:0] x,
			logic signed [UNIFORM_BITS-1:0] y, logic signed [31:0] mean,
			logic [SPREAD_W-1:0] spread);
		longint xl;
		longint yl;
		longint unsigned r;
		longint unsigned w;
		longint unsigned s;
		longint unsigned q;
		normal_result_t res;
		xl = x;
		yl = y;
		if (held_valid) begin
			res.normal_value = scale_add(held_normal, spread, mean);
			res.from_cache = 1'b1;
			held_valid = 1'b0;
			pending_normals.push_back(res);
			return;
		end
		r = xl * xl + yl * yl;
		// Drop pairs outside the unit disk, and the origin.
		if (r == 0 || r > (64'd1 << (2 * FRAC_U)))
			return;
		w = (neg_log2_q24(r) * 64'd23258160) >> 8;
		s = int_sqrt(w);
		q = int_sqrt(r << 16);
		res.normal_value = scale_add(normal_from(xl, s, q), spread, mean);
		res.from_cache = 1'b0;
		held_normal = normal_from(yl, s, q);
		held_valid = 1'b1;
		pending_normals.push_back(res);
	endtask

	// Drive one item at the falling edge and hold it until its transfer.
	task automatic send_item(logic signed [UNIFORM_BITS-1:0] x,
			logic signed [UNIFORM_BITS-1:0] y, logic signed [31:0] mean,
			logic [SPREAD_W-1:0] spread);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		if (gap > 0) begin
			item_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid = 1'b1;
		item_ch.x_uniform = x;
		item_ch.y_uniform = y;
		item_ch.mean = mean;
		item_ch.spread = spread;
		#1;
		while (!item_ch.ready) begin
			@(negedge clk);
			#1;
		end
		@(posedge clk);
		predict_normal(x, y, mean, spread);
	endtask

	// Drop valid first so the last item is not taken twice, then wait for results.
	task automatic wait_drained();
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (pending_normals.size() > 0)
			@(posedge clk);
	endtask

	// Special pairs: exact unit radius, smallest radius, rejections at both ends.
	task automatic test_directed_pairs();
		send_item(-16'sd32768, 16'sd0, 32'sd0, 31'h0001_0000);
		send_item(16'sd5, 16'sd7, 32'sd0, 31'h0001_0000);
		send_item(16'sd0, 16'sd0, 32'sd100, 31'h0001_0000);
		send_item(16'sd32767, 16'sd32767, 32'sd0, 31'h0001_0000);
		send_item(-16'sd32768, -16'sd1, 32'sd0, 31'h0001_0000);
		send_item(16'sd1, 16'sd0, 32'sd0, 31'h7FFF_FFFF);
		send_item(-16'sd1, 16'sd1, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
		send_item(16'sd0, -16'sd1, -32'sh8000_0000, 31'h7FFF_FFFF);
		send_item(16'sd32767, 16'sd0, 32'sd0, 31'h0);
		send_item(16'sd0, 16'sd32767, -32'sd12345, 31'h0000_8000);
		wait_drained();
	endtask

	// Cached items ignore their pair, even one that would be rejected.
	task automatic test_cache_replay();
		send_item(16'sd12000, -16'sd9000, 32'sd0, 31'h0002_0000);
		send_item(16'sd0, 16'sd0, -32'sd65536, 31'h0000_4000);
		send_item(-16'sd20000, 16'sd3, 32'sd500, 31'h7FFF_FFFF);
		send_item(-16'sd32768, -16'sd32768, 32'sh7FFF_0000, 31'h7FFF_FFFF);
		send_item(16'sd100, -16'sd200, -32'sh7FFF_0000, 31'h4000_0000);
		send_item(16'sd32767, 16'sd32767, -32'sh8000_0000, 31'h7FFF_FFFF);
		wait_drained();
	endtask

	// Mostly in-disk pairs with random content and scale; some pairs outside.
	task automatic test_random_pairs();
		logic signed [UNIFORM_BITS-1:0] x;
		logic signed [UNIFORM_BITS-1:0] y;
		logic signed [31:0] mean;
		logic [SPREAD_W-1:0] spread;
		longint r;
		int shift;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 250 == 0)
				calm = ($urandom_range(0, 3) == 0);
			x = UNIFORM_BITS'($urandom);
			y = UNIFORM_BITS'($urandom);
			if ($urandom_range(0, 9) != 0) begin
				// Pull the pair into the disk; sometimes shrink it toward the origin.
				r = longint'(x) * x + longint'(y) * y;
				if (r > (64'sd1 << 30)) begin
					x = x >>> 1;
					y = y >>> 1;
				end
				if ($urandom_range(0, 3) == 0) begin
					shift = $urandom_range(1, 14);
					x = x >>> shift;
					y = y >>> shift;
				end
			end
			mean = $urandom;
			spread = ($urandom_range(0, 4) == 0) ? SPREAD_W'($urandom) :
				SPREAD_W'($urandom_range(0, 32'h0004_0000));
			send_item(x, y, mean, spread);
		end
		calm = 1'b0;
		wait_drained();
	endtask

	// Result side stalls a random number of cycles before each transfer.
	initial begin
		int k;
		result_ch.ready = 1'b0;
		@(negedge clk);
		forever begin
			k = calm ? 0 : $urandom_range(0, 12);
			if (k > 0) begin
				result_ch.ready = 1'b0;
				repeat (k) @(negedge clk);
			end
			result_ch.ready = 1'b1;
			#1;
			while (!result_ch.valid) begin
				@(negedge clk);
				#1;
			end
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		normal_result_t exp_res;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_normals.size() == 0) begin
				errors++;
				$display("%0t: unexpected result normal_value=%0d from_cache=%0b", $time,
					result_ch.normal_value, result_ch.from_cache);
			end else begin
				exp_res = pending_normals.pop_front();
				if (result_ch.normal_value !== exp_res.normal_value) begin
					errors++;
					$display("%0t: normal_value expected %0d actual %0d", $time,
						exp_res.normal_value, result_ch.normal_value);
				end
				if (result_ch.from_cache !== exp_res.from_cache) begin
					errors++;
					$display("%0t: from_cache expected %0b actual %0b", $time,
						exp_res.from_cache, result_ch.from_cache);
				end
			end
		end
	end

	// Watchdog: stop if no transfer happens on either channel for too long.
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		calm = 1'b0;
		held_normal = '0;
		held_valid = 1'b0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.x_uniform = '0;
		item_ch.y_uniform = '0;
		item_ch.mean = '0;
		item_ch.spread = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_directed_pairs();
		test_cache_replay();
		test_random_pairs();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
